/* src/spp_pkg.sv */
// ----------------------------------------------------------------------------
// spp_pkg: shared types and codes for the script push pre-scan
// Phase encoding, verdict and fault codes, opcode constants, mask slice indices,
// scan state and result.
package spp_pkg;

  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_LENGTH = 2'd1,
    PH_SKIP   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  localparam logic [1:0] VERDICT_CONTINUE = 2'd0;
  localparam logic [1:0] VERDICT_SUCCESS  = 2'd1;
  localparam logic [1:0] VERDICT_INVALID  = 2'd2;

  localparam logic [1:0] FAULT_NONE   = 2'd0;
  localparam logic [1:0] FAULT_LEN1   = 2'd1;
  localparam logic [1:0] FAULT_LENN   = 2'd2;
  localparam logic [1:0] FAULT_BEYOND = 2'd3;

  localparam logic [7:0] OPC_DIRECT_MIN = 8'h01;
  localparam logic [7:0] OPC_DIRECT_MAX = 8'h4b;
  localparam logic [7:0] OPC_PUSH1      = 8'h4c;
  localparam logic [7:0] OPC_PUSH2      = 8'h4d;
  localparam logic [7:0] OPC_PUSH4      = 8'h4e;

  localparam logic [1:0] REG_MASK_LOW     = 2'd0;
  localparam logic [1:0] REG_MASK_MIDLOW  = 2'd1;
  localparam logic [1:0] REG_MASK_MIDHIGH = 2'd2;
  localparam logic [1:0] REG_MASK_HIGH    = 2'd3;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  owed;
    logic [2:0]  total;
    logic [31:0] acc;
    logic [31:0] skip;
  } scan_state_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [1:0] fault;
  } scan_result_t;

  localparam scan_state_t SCAN_STATE_RESET = '{
    phase: PH_OPCODE, owed: 3'd0, total: 3'd0, acc: 32'd0, skip: 32'd0
  };

endpackage

/* src/spp_step.sv */
// ----------------------------------------------------------------------------
// spp_step: per-byte scan update
// Next scan state and the verdict for one script byte, purely combinational.
// ----------------------------------------------------------------------------
module spp_step (
  input  spp_pkg::scan_state_t  st,
  input  logic [7:0]            script_byte,
  input  logic                  final_byte,
  input  logic                  mask_bit,
  output spp_pkg::scan_state_t  st_next,
  output spp_pkg::scan_result_t result
);

  logic [1:0]  pos;
  logic [31:0] acc_new;
  logic [2:0]  owed_dec;
  logic [31:0] skip_dec;
  logic        is_direct;
  logic        is_push;
  logic [2:0]  push_len;

  always_comb begin
    pos       = st.total[1:0] - st.owed[1:0];
    acc_new   = st.acc | ({24'd0, script_byte} << {pos, 3'b000});
    owed_dec  = st.owed - 3'd1;
    skip_dec  = st.skip - 32'd1;
    is_direct = (script_byte >= spp_pkg::OPC_DIRECT_MIN) &&
                (script_byte <= spp_pkg::OPC_DIRECT_MAX);
    is_push   = (script_byte == spp_pkg::OPC_PUSH1) ||
                (script_byte == spp_pkg::OPC_PUSH2) ||
                (script_byte == spp_pkg::OPC_PUSH4);
    if (script_byte == spp_pkg::OPC_PUSH1) begin
      push_len = 3'd1;
    end else if (script_byte == spp_pkg::OPC_PUSH2) begin
      push_len = 3'd2;
    end else begin
      push_len = 3'd4;
    end
  end

  // next state
  always_comb begin
    st_next = st;
    case (st.phase)
      spp_pkg::PH_DONE: begin
      end
      spp_pkg::PH_LENGTH: begin
        st_next.acc  = acc_new;
        st_next.owed = owed_dec;
        if (owed_dec == 3'd0) begin
          st_next.skip  = acc_new;
          st_next.phase = (acc_new == 32'd0) ? spp_pkg::PH_OPCODE : spp_pkg::PH_SKIP;
        end
      end
      spp_pkg::PH_SKIP: begin
        st_next.skip = skip_dec;
        if (skip_dec == 32'd0) begin
          st_next.phase = spp_pkg::PH_OPCODE;
        end
      end
      spp_pkg::PH_OPCODE: begin
        if (mask_bit) begin
          st_next.phase = spp_pkg::PH_DONE;
        end else if (is_direct) begin
          st_next.skip  = {24'd0, script_byte};
          st_next.phase = spp_pkg::PH_SKIP;
        end else if (is_push) begin
          st_next.owed  = push_len;
          st_next.total = push_len;
          st_next.acc   = 32'd0;
          st_next.phase = spp_pkg::PH_LENGTH;
        end
      end
      default: begin
        st_next = spp_pkg::SCAN_STATE_RESET;
      end
    endcase
    // a verdict always starts the next script from scratch
    if (final_byte) begin
      st_next = spp_pkg::SCAN_STATE_RESET;
    end
  end

  // verdict, only meaningful on a final byte
  always_comb begin
    result.verdict = spp_pkg::VERDICT_CONTINUE;
    result.fault   = spp_pkg::FAULT_NONE;
    case (st.phase)
      spp_pkg::PH_DONE: begin
        result.verdict = spp_pkg::VERDICT_SUCCESS;
      end
      spp_pkg::PH_LENGTH: begin
        if (owed_dec != 3'd0) begin
          result.verdict = spp_pkg::VERDICT_INVALID;
          result.fault   = (st.total == 3'd1) ? spp_pkg::FAULT_LEN1 : spp_pkg::FAULT_LENN;
        end else if (acc_new != 32'd0) begin
          result.verdict = spp_pkg::VERDICT_INVALID;
          result.fault   = spp_pkg::FAULT_BEYOND;
        end
      end
      spp_pkg::PH_SKIP: begin
        if (skip_dec != 32'd0) begin
          result.verdict = spp_pkg::VERDICT_INVALID;
          result.fault   = spp_pkg::FAULT_BEYOND;
        end
      end
      spp_pkg::PH_OPCODE: begin
        if (mask_bit) begin
          result.verdict = spp_pkg::VERDICT_SUCCESS;
        end else if (is_direct) begin
          result.verdict = spp_pkg::VERDICT_INVALID;
          result.fault   = spp_pkg::FAULT_BEYOND;
        end else if (is_push) begin
          result.verdict = spp_pkg::VERDICT_INVALID;
          result.fault   = (push_len == 3'd1) ? spp_pkg::FAULT_LEN1 : spp_pkg::FAULT_LENN;
        end
      end
      default: begin
        result.verdict = spp_pkg::VERDICT_CONTINUE;
      end
    endcase
  end

endmodule

/* src/script_push_prescan.sv */
// ----------------------------------------------------------------------------
// script_push_prescan: streaming success-opcode pre-scan of a script
// Decodes opcodes and push lengths, skips push data, gives one verdict per
// script on its last byte.
// ----------------------------------------------------------------------------
// channel  | dir | beat carries                         | beats
// ---------+-----+--------------------------------------+------------------
// s_*      | in  | tdata: script_byte; tlast: final_byte | one per byte
// m_*      | out | tdata: verdict, fault                 | one per script
// cfg_*    | in  | 64-bit success mask slice, index 0..3 | any idle cycle
//
// One byte per cycle: the scan state updates in the cycle the beat is taken.
// The verdict sits in a single output register from the cycle after the last byte.
// s_tready drops only while that register is full and m_tready is low.
// Reset clears the scan state and all four mask slices.
module script_push_prescan (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] script_byte
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [1:0] verdict, [3:2] fault, [7:4] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [255:0]          success_mask;
  spp_pkg::scan_state_t  st;
  spp_pkg::scan_state_t  st_next;
  spp_pkg::scan_result_t result;
  logic                  accept;
  logic                  mask_bit;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign mask_bit = success_mask[s_tdata];

  always_ff @(posedge clk) begin
    if (rst) begin
      success_mask <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spp_pkg::REG_MASK_LOW:     success_mask[63:0]    <= cfg_data;
        spp_pkg::REG_MASK_MIDLOW:  success_mask[127:64]  <= cfg_data;
        spp_pkg::REG_MASK_MIDHIGH: success_mask[191:128] <= cfg_data;
        spp_pkg::REG_MASK_HIGH:    success_mask[255:192] <= cfg_data;
        default:                   success_mask          <= success_mask;
      endcase
    end
  end

  spp_step u_step (
    .st          (st),
    .script_byte (s_tdata),
    .final_byte  (s_tlast),
    .mask_bit    (mask_bit),
    .st_next     (st_next),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= spp_pkg::SCAN_STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept && s_tlast) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      m_tdata <= {4'd0, result.fault, result.verdict};
    end
  end

endmodule

/* src/spp_checker.sv */
// ----------------------------------------------------------------------------
// spp_checker: port-level checks for script_push_prescan
// Verdict encoding and output timing as seen on the ports.
// ----------------------------------------------------------------------------
module spp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  // stalled verdict holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("verdict beat changed while stalled");

  // a fault code only accompanies an invalid verdict
  a_fault: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[3:2] != spp_pkg::FAULT_NONE)
      |-> m_tdata[1:0] == spp_pkg::VERDICT_INVALID)
    else $error("fault code without invalid verdict");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3) && (m_tdata[7:4] == 4'd0))
    else $error("bad verdict code or padding");

  // a verdict appears only after the last byte of a script was taken
  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
    else $error("verdict without a final byte");

  // input never stalls while the output register is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input stalled with output free");

endmodule

bind script_push_prescan spp_checker u_spp_checker (.*);

/* test/script_push_prescan_tb.sv */
// ----------------------------------------------------------------------------
// script_push_prescan_tb: self-checking bench for the script push pre-scan
// Streams scripts byte by byte and predicts each script's verdict and fault
// from a local scan model. Runs directed scripts first, then random scripts
// under several mask settings and several idle and stall patterns.
// ----------------------------------------------------------------------------
module script_push_prescan_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] octet_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] script_byte
  logic        s_tlast = 1'b0;   // final_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;          // [1:0] verdict, [3:2] fault, [7:4] zero
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = spp_pkg::REG_MASK_LOW;
  logic [63:0] cfg_data = 64'd0;

  // scan model
  logic [63:0]           mask_reg [4] = '{default: 64'd0};
  spp_pkg::scan_state_t  scan_st = spp_pkg::SCAN_STATE_RESET;
  logic [1:0]            held_verdict = spp_pkg::VERDICT_CONTINUE;
  spp_pkg::scan_result_t verdict_q [$];
  octet_t                script_buf [$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int err_count = 0;
  int scanned_bytes = 0;

  script_push_prescan DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("script_push_prescan verification failed");
    $finish;
  end

  // Advances the scan by one byte; returns 1 when the byte closes a script.
  function automatic bit scan_predict(input octet_t b, input bit is_last,
                                      output spp_pkg::scan_result_t res);
    logic [1:0] pos;
    logic [2:0] n;
    bit         early;
    logic [1:0] f;
    early = 1'b0;
    f = spp_pkg::FAULT_NONE;
    res.verdict = spp_pkg::VERDICT_CONTINUE;
    res.fault = spp_pkg::FAULT_NONE;
    scanned_bytes++;
    case (scan_st.phase)
      spp_pkg::PH_DONE: ;
      spp_pkg::PH_LENGTH: begin
        pos = 2'(scan_st.total - scan_st.owed);
        scan_st.acc = scan_st.acc | (32'(b) << (8 * pos));
        scan_st.owed = scan_st.owed - 3'd1;
        if (scan_st.owed == 3'd0) begin
          scan_st.skip = scan_st.acc;
          scan_st.phase = (scan_st.acc == 32'd0) ? spp_pkg::PH_OPCODE : spp_pkg::PH_SKIP;
        end
        if (is_last && scan_st.owed != 3'd0) begin
          early = 1'b1;
          f = (scan_st.total == 3'd1) ? spp_pkg::FAULT_LEN1 : spp_pkg::FAULT_LENN;
        end else if (is_last && scan_st.skip != 32'd0) begin
          early = 1'b1;
          f = spp_pkg::FAULT_BEYOND;
        end
      end
      spp_pkg::PH_SKIP: begin
        scan_st.skip = scan_st.skip - 32'd1;
        if (scan_st.skip == 32'd0) scan_st.phase = spp_pkg::PH_OPCODE;
        if (is_last && scan_st.skip != 32'd0) begin
          early = 1'b1;
          f = spp_pkg::FAULT_BEYOND;
        end
      end
      default: begin
        // mask check ahead of push decoding: success wins on push opcodes
        if (mask_reg[b[7:6]][b[5:0]]) begin
          held_verdict = spp_pkg::VERDICT_SUCCESS;
          scan_st.phase = spp_pkg::PH_DONE;
        end else if (b >= spp_pkg::OPC_DIRECT_MIN && b <= spp_pkg::OPC_DIRECT_MAX) begin
          scan_st.skip = 32'(b);
          scan_st.phase = spp_pkg::PH_SKIP;
          if (is_last) begin
            early = 1'b1;
            f = spp_pkg::FAULT_BEYOND;
          end
        end else if (b == spp_pkg::OPC_PUSH1 || b == spp_pkg::OPC_PUSH2 ||
                     b == spp_pkg::OPC_PUSH4) begin
          n = (b == spp_pkg::OPC_PUSH1) ? 3'd1 : (b == spp_pkg::OPC_PUSH2) ? 3'd2 : 3'd4;
          scan_st.owed = n;
          scan_st.total = n;
          scan_st.acc = 32'd0;
          scan_st.phase = spp_pkg::PH_LENGTH;
          if (is_last) begin
            early = 1'b1;
            f = (n == 3'd1) ? spp_pkg::FAULT_LEN1 : spp_pkg::FAULT_LENN;
          end
        end
      end
    endcase
    if (!is_last) return 1'b0;
    res.verdict = early ? spp_pkg::VERDICT_INVALID : held_verdict;
    res.fault = f;
    scan_st = spp_pkg::SCAN_STATE_RESET;
    held_verdict = spp_pkg::VERDICT_CONTINUE;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    spp_pkg::scan_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: verdict beat with nothing expected, actual %h", $time, m_tdata);
        err_count++;
      end else begin
        want = verdict_q.pop_front();
        if (m_tdata[1:0] !== want.verdict) begin
          $display("%0t: verdict expected %0d actual %0d", $time, want.verdict,
                   m_tdata[1:0]);
          err_count++;
        end
        if (m_tdata[3:2] !== want.fault) begin
          $display("%0t: fault expected %0d actual %0d", $time, want.fault,
                   m_tdata[3:2]);
          err_count++;
        end
      end
    end
  end

  // one beat; s_tvalid stays high into the next byte unless a gap is drawn
  task automatic push_byte(input octet_t b, input bit is_last);
    spp_pkg::scan_result_t r;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (scan_predict(b, is_last, r)) verdict_q.insert(verdict_q.size(), r);
  endtask

  task automatic send_script();
    foreach (script_buf[i]) push_byte(script_buf[i], i == script_buf.size() - 1);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_masks(input logic [63:0] m0, input logic [63:0] m1,
                           input logic [63:0] m2, input logic [63:0] m3);
    logic [1:0]  idx [4];
    logic [63:0] val [4];
    idx = '{spp_pkg::REG_MASK_LOW, spp_pkg::REG_MASK_MIDLOW,
            spp_pkg::REG_MASK_MIDHIGH, spp_pkg::REG_MASK_HIGH};
    val = '{m0, m1, m2, m3};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      mask_reg[idx[i]] = val[i];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand_mask();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] sparse_mask();
    logic [63:0] m;
    m = 64'd0;
    repeat ($urandom_range(3)) m[$urandom_range(63)] = 1'b1;
    return m;
  endfunction

  task automatic set_idling(input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct = stall;
  endtask

  function automatic void add_byte(input octet_t b);
    script_buf.insert(script_buf.size(), b);
  endfunction

  // appends one opcode or push, with its length bytes and data
  task automatic add_op();
    int     kind;
    int     len;
    octet_t op;
    kind = $urandom_range(9);
    if (kind <= 3) begin
      do op = octet_t'($urandom_range(255));
      while (op >= spp_pkg::OPC_DIRECT_MIN && op <= spp_pkg::OPC_PUSH4);
      add_byte(op);
    end else begin
      if (kind <= 5) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(75, 1) : $urandom_range(6, 1);
        add_byte(octet_t'(len));
      end else if (kind <= 7) begin
        len = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(8);
        add_byte(spp_pkg::OPC_PUSH1);
        add_byte(len[7:0]);
      end else if (kind == 8) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(300, 256) : $urandom_range(6);
        add_byte(spp_pkg::OPC_PUSH2);
        add_byte(len[7:0]);
        add_byte(len[15:8]);
      end else begin
        len = $urandom_range(6);
        add_byte(spp_pkg::OPC_PUSH4);
        add_byte(len[7:0]);
        add_byte(len[15:8]);
        add_byte(len[23:16]);
        add_byte(len[31:24]);
      end
      repeat (len) add_byte(octet_t'($urandom_range(255)));
    end
  endtask

  // mostly complete scripts, some cut short, some plain noise
  task automatic send_random_script();
    int pick;
    int cut;
    script_buf.delete();
    pick = $urandom_range(19);
    if (pick < 2) begin
      repeat ($urandom_range(6, 1)) add_byte(octet_t'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(5, 1)) add_op();
      if (pick < 5 && script_buf.size() > 1) begin
        cut = $urandom_range(script_buf.size() - 1, 1);
        script_buf = script_buf[0:cut-1];
      end
    end
    send_script();
  endtask

  task automatic run_random(input int quota);
    int stop;
    stop = scanned_bytes + quota;
    while (scanned_bytes < stop) send_random_script();
  endtask

  // masks still at reset: truncations, zero-length and maximal pushes
  task automatic test_reset_defaults();
    set_idling(0, 0);
    script_buf = '{8'h00};                                 send_script();
    script_buf = '{spp_pkg::OPC_DIRECT_MIN};               send_script();
    script_buf = '{spp_pkg::OPC_DIRECT_MAX};               send_script();
    script_buf = '{spp_pkg::OPC_PUSH1};                    send_script();
    script_buf = '{spp_pkg::OPC_PUSH2};                    send_script();
    script_buf = '{spp_pkg::OPC_PUSH4};                    send_script();
    script_buf = '{spp_pkg::OPC_PUSH1, 8'h00};             send_script();
    script_buf = '{spp_pkg::OPC_PUSH2, 8'h00, 8'h00};      send_script();
    script_buf = '{spp_pkg::OPC_PUSH4, 8'h02, 8'h00, 8'h00, 8'h00};
    send_script();
    script_buf = '{8'h02, 8'haa, 8'hbb};                   send_script();
    script_buf = '{8'h02, 8'haa};                          send_script();
    script_buf = '{spp_pkg::OPC_PUSH4, 8'hff, 8'hff, 8'hff, 8'hff};
    send_script();
  endtask

  // success on a push opcode, on pushed data (must not fire), and trailing bytes
  task automatic test_success_mask();
    wait_idle();
    // 0x00, 0x4c, 0x50 and 0xff flagged
    set_masks(64'h1, (64'h1 << (spp_pkg::OPC_PUSH1 - 8'h40)) | (64'h1 << 16), 64'd0,
              64'h1 << 63);
    script_buf = '{spp_pkg::OPC_PUSH1};                    send_script();
    script_buf = '{spp_pkg::OPC_DIRECT_MIN, 8'h50};        send_script();
    script_buf = '{8'h50, spp_pkg::OPC_PUSH4};             send_script();
    script_buf = '{8'hff};                                 send_script();
    script_buf = '{8'h00};                                 send_script();
  endtask

  task automatic test_no_idle();
    set_idling(0, 0);
    wait_idle();
    set_masks(64'd0, 64'd0, 64'd0, 64'd0);
    run_random(230);
    wait_idle();
    set_masks('1, '1, '1, '1);
    run_random(40);
  endtask

  task automatic test_sender_idle();
    set_idling(65, 0);
    wait_idle();
    set_masks(rand_mask(), rand_mask(), rand_mask(), rand_mask());
    run_random(230);
    wait_idle();
    set_masks(sparse_mask(), sparse_mask(), sparse_mask(), sparse_mask());
    run_random(230);
  endtask

  task automatic test_receiver_stall();
    set_idling(0, 65);
    wait_idle();
    set_masks(sparse_mask() | (64'h1 << spp_pkg::OPC_DIRECT_MIN),
              sparse_mask() | (64'h1 << (spp_pkg::OPC_PUSH2 - 8'h40)),
              sparse_mask(), sparse_mask());
    run_random(230);
    wait_idle();
    set_masks(sparse_mask(), sparse_mask(), sparse_mask(), sparse_mask());
    run_random(230);
  endtask

  task automatic test_both_idle();
    set_idling(35, 35);
    wait_idle();
    set_masks(sparse_mask(), rand_mask() & rand_mask(), sparse_mask(), rand_mask());
    run_random(230);
    wait_idle();
    set_masks(64'd0, 64'd0, 64'd0, 64'd0);
    run_random(230);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_success_mask();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    wait_idle();
    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
      err_count++;
    end
    if (err_count == 0)
      $display("script_push_prescan verification clean");
    else
      $display("script_push_prescan verification failed");
    $finish;
  end

endmodule

/* script_push_prescan.f */
src/spp_pkg.sv
src/spp_step.sv
src/script_push_prescan.sv
src/spp_checker.sv
test/script_push_prescan_tb.sv
